@@ rtl/bba_pkg.sv @@
// Shared types, codes and helpers for the block bitmap allocator.
// Self-contained; imported by bba_grp_div and block_bitmap_allocator_top.
package bba_pkg;

   // default geometry of the bitmap store
   localparam int GROUP_BYTES_DEF = 1024;
   localparam int GROUPS_DEF      = 4;

   // byte value with every block in use
   localparam logic [7:0] BYTE_FULL = 8'hFF;

   // reset values of the registers
   localparam logic [14:0] DATA_START_RST   = 15'd0;
   localparam logic [15:0] TOTAL_BLOCKS_RST = 16'd32768;

   // result status codes
   typedef enum logic [2:0] {
      ST_OK           = 3'd0,
      ST_ALREADY_FREE = 3'd1,
      ST_INVALID      = 3'd2,
      ST_NO_FREE      = 3'd3,
      ST_OUT_OF_RANGE = 3'd4
   } bba_status_type;

   // request kinds
   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } bba_op_type;

   // register indexes
   typedef enum logic {
      CSR_DATA_START   = 1'b0,
      CSR_TOTAL_BLOCKS = 1'b1
   } bba_csr_type;

   // status of the group index divider
   typedef struct packed {
      logic busy;
      logic done;
   } bba_div_stat_type;

   // position of the first clear bit, most significant bit first
   function automatic logic [2:0] first_clear(input logic [7:0] b);
      logic [2:0] k;
      logic       hit;
      k   = 3'd0;
      hit = 1'b0;
      for (int i = 0; i < 8; i++) begin
         if (!hit && !b[7-i]) begin
            k   = 3'(i);
            hit = 1'b1;
         end
      end
      return k;
   endfunction

endpackage

@@ rtl/block_bitmap_allocator_top.sv @@
// Block bitmap allocator, first fit, over a byte-wide bitmap RAM and a group count RAM.
// Requests are rejected at decode or go on to the scans (allocate) or the divider (free);
// the scans read one RAM entry per cycle.
// One request at a time: the next is taken in the cycle after the result is loaded, and a
// result still waiting in the output register holds off the following load.
// Reset (synchronous) runs a clearing pass over all GROUPS*GROUP_BYTES bytes (4096 by default).
module block_bitmap_allocator_top import bba_pkg::*; #(
   parameter int GROUP_BYTES = GROUP_BYTES_DEF,
   parameter int GROUPS      = GROUPS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [14:0] block index, [15] zero
   input  logic        req_tuser,   // [0] op
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [14:0] allocated_block, [30:15] blocks_free, [31] zero
   output logic [2:0]  rsp_tuser,   // [2:0] status
   // register write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [15:0] csr_data
);

   localparam int STORE_BYTES = GROUPS * GROUP_BYTES;
   localparam int GROUP_BITS  = GROUP_BYTES * 8;
   localparam int STORE_BITS  = STORE_BYTES * 8;
   localparam int AW          = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
   localparam int GAW         = (GROUPS > 1) ? $clog2(GROUPS) : 1;
   localparam int GF_W        = $clog2(GROUP_BITS + 1);
   localparam int FC_W        = $clog2(STORE_BITS + 1);
   localparam int FCX_W       = (FC_W > 16) ? FC_W : 16;
   localparam int SCAN_MAX    = (GROUPS > GROUP_BYTES) ? GROUPS : GROUP_BYTES;
   localparam int CW          = $clog2(SCAN_MAX + 1);
   localparam int NW          = (AW + 3 > 16) ? AW + 3 : 16;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_DECODE, S_GSCAN, S_BSCAN, S_ACOMMIT,
      S_FDIV, S_FCHECK, S_DONE
   } state_type;

   // control registers
   state_type         state_ff, state_in;
   logic [AW-1:0]     clr_ff, clr_in;
   logic [FC_W-1:0]   free_cnt_ff, free_cnt_in;
   logic [14:0]       data_start_ff, data_start_in;
   logic [15:0]       total_ff, total_in;
   logic              pend_ff, pend_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic              op_ff, op_in;
   logic [14:0]       blk_ff, blk_in;
   logic [CW-1:0]     pidx_ff, pidx_in;
   logic [AW-1:0]     base_ff, base_in;
   logic [AW-1:0]     paddr_ff, paddr_in;
   logic [AW-1:0]     addr_ff, addr_in;
   logic [7:0]        byte_ff, byte_in;
   logic [GAW-1:0]    grp_ff, grp_in;
   logic [GF_W-1:0]   gcnt_ff, gcnt_in;
   bba_status_type    res_status_ff, res_status_in;
   logic [14:0]       res_blk_ff, res_blk_in;
   bba_status_type    rsp_status_ff, rsp_status_in;
   logic [14:0]       rsp_blk_ff, rsp_blk_in;
   logic [15:0]       rsp_free_ff, rsp_free_in;

   // RAM ports
   logic              byte_we, byte_re;
   logic [AW-1:0]     byte_waddr, byte_raddr;
   logic [7:0]        byte_wdata, byte_rdata;
   logic              gf_we, gf_re;
   logic [GAW-1:0]    gf_waddr, gf_raddr;
   logic [GF_W-1:0]   gf_wdata, gf_rdata;

   // divider
   logic              div_start;
   bba_div_stat_type  div_stat;
   logic [GAW-1:0]    div_grp;

   // decode helpers
   logic [NW-1:0]     blk_x;
   logic [AW-1:0]     blk_byte;
   logic [7:0]        blk_mask;
   logic              free_bad;
   logic [2:0]        alloc_bit;
   logic [NW-1:0]     alloc_blk;
   logic              alloc_oor;
   logic [AW-1:0]     scan_addr;
   logic              rsp_slot;
   logic [FCX_W-1:0]  free_x;

   bba_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_bitmap (
      .clock (clock),
      .we    (byte_we),
      .waddr (byte_waddr),
      .wdata (byte_wdata),
      .re    (byte_re),
      .raddr (byte_raddr),
      .rdata (byte_rdata)
   );

   bba_ram #(.WIDTH(GF_W), .DEPTH(GROUPS)) u_grp_free (
      .clock (clock),
      .we    (gf_we),
      .waddr (gf_waddr),
      .wdata (gf_wdata),
      .re    (gf_re),
      .raddr (gf_raddr),
      .rdata (gf_rdata)
   );

   bba_grp_div #(.GROUP_BYTES(GROUP_BYTES), .GROUPS(GROUPS)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .value (blk_ff),
      .stat  (div_stat),
      .grp   (div_grp)
   );

   assign blk_x     = NW'(blk_ff);
   assign blk_byte  = AW'(blk_x[NW-1:3]);
   assign blk_mask  = 8'h80 >> blk_ff[2:0];
   assign free_bad  = (blk_x <= NW'(data_start_ff)) || (blk_x >= NW'(total_ff)) ||
                      (blk_x > NW'(STORE_BITS - 1));
   assign alloc_bit = first_clear(byte_ff);
   assign alloc_blk = NW'({addr_ff, alloc_bit});
   assign alloc_oor = alloc_blk >= NW'(total_ff);
   assign scan_addr = base_ff + AW'(cnt_ff);
   assign rsp_slot  = !rsp_valid_ff || rsp_tready;
   assign free_x    = FCX_W'(free_cnt_ff);

   // register writes, taken at any time
   assign csr_ready = 1'b1;
   always_comb begin
      data_start_in = data_start_ff;
      total_in      = total_ff;
      if (csr_valid) begin
         case (bba_csr_type'(csr_index))
            CSR_DATA_START:   data_start_in = csr_data[14:0];
            CSR_TOTAL_BLOCKS: total_in      = csr_data;
            default:          total_in      = total_ff;
         endcase
      end
   end

   // sequencer: clear, decode, scan or divide, read-modify-write, hand off
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      free_cnt_in   = free_cnt_ff;
      pend_in       = pend_ff;
      cnt_in        = cnt_ff;
      op_in         = op_ff;
      blk_in        = blk_ff;
      pidx_in       = pidx_ff;
      base_in       = base_ff;
      paddr_in      = paddr_ff;
      addr_in       = addr_ff;
      byte_in       = byte_ff;
      grp_in        = grp_ff;
      gcnt_in       = gcnt_ff;
      res_status_in = res_status_ff;
      res_blk_in    = res_blk_ff;
      byte_we       = 1'b0;
      byte_waddr    = addr_ff;
      byte_wdata    = byte_ff;
      byte_re       = 1'b0;
      byte_raddr    = scan_addr;
      gf_we         = 1'b0;
      gf_waddr      = grp_ff;
      gf_wdata      = gcnt_ff;
      gf_re         = 1'b0;
      gf_raddr      = GAW'(cnt_ff);
      div_start     = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            byte_we    = 1'b1;
            byte_waddr = clr_ff;
            byte_wdata = '0;
            gf_we      = AW'(clr_ff) < AW'(GROUPS - 1) || clr_ff == AW'(GROUPS - 1);
            gf_waddr   = GAW'(clr_ff);
            gf_wdata   = GF_W'(GROUP_BITS);
            clr_in     = clr_ff + AW'(1);
            if (clr_ff == AW'(STORE_BYTES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               op_in    = req_tuser;
               blk_in   = req_tdata[14:0];
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            res_blk_in = '0;
            pend_in    = 1'b0;
            cnt_in     = '0;
            if (bba_op_type'(op_ff) == OP_ALLOC) begin
               if (free_cnt_ff == '0) begin
                  res_status_in = ST_NO_FREE;
                  state_in      = S_DONE;
               end else begin
                  state_in = S_GSCAN;
               end
            end else if (free_bad) begin
               res_status_in = ST_INVALID;
               state_in      = S_DONE;
            end else begin
               div_start = 1'b1;
               state_in  = S_FDIV;
            end
         end
         S_GSCAN: begin
            // check last cycle's read while issuing the next group
            if (pend_ff && gf_rdata != '0) begin
               grp_in   = GAW'(pidx_ff);
               gcnt_in  = gf_rdata;
               base_in  = AW'(pidx_ff) * AW'(GROUP_BYTES);
               cnt_in   = '0;
               pend_in  = 1'b0;
               state_in = S_BSCAN;
            end else if (pend_ff && pidx_ff == CW'(GROUPS - 1)) begin
               res_status_in = ST_NO_FREE;
               state_in      = S_DONE;
            end else begin
               gf_re   = 1'b1;
               pend_in = 1'b1;
               pidx_in = cnt_ff;
               cnt_in  = cnt_ff + CW'(1);
            end
         end
         S_BSCAN: begin
            if (pend_ff && byte_rdata != BYTE_FULL) begin
               byte_in  = byte_rdata;
               addr_in  = paddr_ff;
               state_in = S_ACOMMIT;
            end else if (pend_ff && pidx_ff == CW'(GROUP_BYTES - 1)) begin
               res_status_in = ST_NO_FREE;
               state_in      = S_DONE;
            end else begin
               byte_re  = 1'b1;
               pend_in  = 1'b1;
               pidx_in  = cnt_ff;
               paddr_in = scan_addr;
               cnt_in   = cnt_ff + CW'(1);
            end
         end
         S_ACOMMIT: begin
            if (alloc_oor) begin
               res_status_in = ST_OUT_OF_RANGE;
            end else begin
               byte_we       = 1'b1;
               byte_wdata    = byte_ff | (8'h80 >> alloc_bit);
               gf_we         = 1'b1;
               gf_wdata      = gcnt_ff - GF_W'(1);
               free_cnt_in   = free_cnt_ff - FC_W'(1);
               res_status_in = ST_OK;
               res_blk_in    = alloc_blk[14:0];
            end
            state_in = S_DONE;
         end
         S_FDIV: begin
            if (div_stat.done) begin
               byte_re    = 1'b1;
               byte_raddr = blk_byte;
               gf_re      = 1'b1;
               gf_raddr   = div_grp;
               grp_in     = div_grp;
               state_in   = S_FCHECK;
            end
         end
         S_FCHECK: begin
            if ((byte_rdata & blk_mask) == '0) begin
               res_status_in = ST_ALREADY_FREE;
            end else begin
               byte_we       = 1'b1;
               byte_waddr    = blk_byte;
               byte_wdata    = byte_rdata & ~blk_mask;
               gf_we         = 1'b1;
               gf_wdata      = gf_rdata + GF_W'(1);
               free_cnt_in   = free_cnt_ff + FC_W'(1);
               res_status_in = ST_OK;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (rsp_slot) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // output register: load when the sequencer finishes and the slot is free
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_blk_in    = rsp_blk_ff;
      rsp_free_in   = rsp_free_ff;
      if (state_ff == S_DONE && rsp_slot) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_blk_in    = res_blk_ff;
         rsp_free_in   = free_x[15:0];
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ff        <= '0;
         free_cnt_ff   <= FC_W'(STORE_BITS);
         data_start_ff <= DATA_START_RST;
         total_ff      <= TOTAL_BLOCKS_RST;
         pend_ff       <= 1'b0;
         cnt_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         free_cnt_ff   <= free_cnt_in;
         data_start_ff <= data_start_in;
         total_ff      <= total_in;
         pend_ff       <= pend_in;
         cnt_ff        <= cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      op_ff         <= op_in;
      blk_ff        <= blk_in;
      pidx_ff       <= pidx_in;
      base_ff       <= base_in;
      paddr_ff      <= paddr_in;
      addr_ff       <= addr_in;
      byte_ff       <= byte_in;
      grp_ff        <= grp_in;
      gcnt_ff       <= gcnt_in;
      res_status_ff <= res_status_in;
      res_blk_ff    <= res_blk_in;
      rsp_status_ff <= rsp_status_in;
      rsp_blk_ff    <= rsp_blk_in;
      rsp_free_ff   <= rsp_free_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {1'b0, rsp_free_ff, rsp_blk_ff};

   // a successful allocate takes exactly one block from the free count
   a_alloc_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ACOMMIT && !alloc_oor) |=>
         free_cnt_ff == $past(free_cnt_ff) - FC_W'(1))
      else $error("free count not decremented after allocate");

   // a successful free returns exactly one block to the free count
   a_free_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FCHECK && (byte_rdata & blk_mask) != '0) |=>
         free_cnt_ff == $past(free_cnt_ff) + FC_W'(1))
      else $error("free count not incremented after free");

   // the byte scan only commits on a byte with a clear bit
   a_commit_byte: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_ACOMMIT |-> byte_ff != BYTE_FULL)
      else $error("allocate commit on a full byte");

   // the divider is running whenever the sequencer waits on it
   a_div_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FDIV |-> div_stat.busy)
      else $error("waiting on an idle divider");

   // no request is taken and no result is offered while the clearing pass runs
   a_clear_block: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |-> !req_tready && !rsp_tvalid)
      else $error("handshake active during clearing pass");

endmodule

@@ rtl/bba_ram.sv @@
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module bba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write, then registered read that holds when not enabled
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/bba_grp_div.sv @@
// Iterative group index unit: divides a block number by the group size
// by repeated subtraction, one group per cycle. Uses bba_pkg.
module bba_grp_div import bba_pkg::*; #(
   parameter int GROUP_BYTES = GROUP_BYTES_DEF,
   parameter int GROUPS      = GROUPS_DEF,
   localparam int GROUP_BITS = GROUP_BYTES * 8,
   localparam int GAW        = (GROUPS > 1) ? $clog2(GROUPS) : 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [14:0]      value,
   output bba_div_stat_type stat,
   output logic [GAW-1:0]   grp
);

   logic           busy_ff, busy_in;
   logic [15:0]    rem_ff, rem_in;
   logic [GAW-1:0] quo_ff, quo_in;
   logic           ge;

   assign ge = rem_ff >= 16'(GROUP_BITS);

   // load on start, subtract one group per cycle, stop when below a group
   always_comb begin
      busy_in = busy_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         rem_in  = 16'(value);
         quo_in  = '0;
      end else if (busy_ff) begin
         if (ge) begin
            rem_in = rem_ff - 16'(GROUP_BITS);
            quo_in = quo_ff + GAW'(1);
         end else begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = busy_ff && !ge;
   assign grp       = quo_ff;

endmodule
